>>> rtl/core/rrts_pkg.sv
// Types, codes and defaults shared by the thread scheduler modules.
package rrts_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 8;

  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_RUNNABLE = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_BLOCKED  = 3'd3,
    ST_ZOMBIE   = 3'd4
  } slot_state_e;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_YIELD  = 2'd1,
    CMD_EXIT   = 2'd2,
    CMD_JOIN   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_BADJOIN = 2'd2,
    STATUS_BLOCKED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SHIFT,
    OP_CREATE_SET,
    OP_EXIT,
    OP_SWITCH,
    OP_REAP,
    OP_BLOCK
  } cell_op_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_EXEC,
    CS_LOAD,
    CS_SCAN,
    CS_FINISH
  } ctrl_state_e;

  typedef struct packed {
    cell_op_e    op;
    slot_state_e want;
  } cell_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] target_thread;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] created_thread;
    logic       switched;
    logic [2:0] previous_thread;
    logic [2:0] running_thread;
  } out_beat_t;

endpackage

>>> rtl/core/rrts_cell.sv
// One thread slot: its state, the slot it waits on and the search token.
module rrts_cell #(
  parameter int unsigned SlotCount = 8,
  parameter int unsigned CellIdx   = 0,
  parameter int unsigned IdxW      = 3,
  parameter int unsigned WaitW     = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rrts_pkg::cell_cmd_t  cmd_i,
  input  logic [IdxW-1:0]      cur_idx_i,
  input  logic [IdxW-1:0]      sel_idx_i,
  input  logic                 token_i,
  output logic                 token_o,
  output logic                 match_o,
  output logic [2:0]           rd_state_o,
  output logic                 run_o
);
  import rrts_pkg::*;

  localparam logic [WaitW-1:0] WaitNone = WaitW'(SlotCount);
  localparam logic [IdxW-1:0]  MyIdx    = IdxW'(CellIdx);

  slot_state_e      state_q, state_d;
  logic [WaitW-1:0] waits_q, waits_d;
  logic             token_q, token_d;
  logic             is_cur, is_sel;

  assign is_cur = (cur_idx_i == MyIdx);
  assign is_sel = (sel_idx_i == MyIdx);

  always_comb begin
    state_d = state_q;
    waits_d = waits_q;
    token_d = token_q;
    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        token_d = is_sel;
      end
      OP_SHIFT: begin
        token_d = token_i;
      end
      OP_CREATE_SET: begin
        if (is_sel) begin
          state_d = ST_RUNNABLE;
          waits_d = WaitNone;
        end
      end
      OP_EXIT: begin
        if (is_cur) begin
          state_d = ST_ZOMBIE;
        end else if (state_q == ST_BLOCKED && waits_q == WaitW'(cur_idx_i)) begin
          // A joiner of the exiting thread wakes up.
          state_d = ST_RUNNABLE;
          waits_d = WaitNone;
        end
      end
      OP_SWITCH: begin
        // The chosen slot wins when it is also the outgoing one.
        if (is_sel) begin
          state_d = ST_RUNNING;
        end else if (is_cur && state_q == ST_RUNNING) begin
          state_d = ST_RUNNABLE;
        end
      end
      OP_REAP: begin
        if (is_sel) begin
          state_d = ST_UNUSED;
          waits_d = WaitNone;
        end
      end
      OP_BLOCK: begin
        if (is_cur) begin
          state_d = ST_BLOCKED;
          waits_d = WaitW'(sel_idx_i);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= (CellIdx == 0) ? ST_RUNNING : ST_UNUSED;
      waits_q <= WaitNone;
      token_q <= 1'b0;
    end else begin
      state_q <= state_d;
      waits_q <= waits_d;
      token_q <= token_d;
    end
  end

  assign token_o    = token_q;
  assign match_o    = token_q && (state_q == cmd_i.want);
  assign rd_state_o = is_sel ? state_q : ST_UNUSED;
  assign run_o      = (state_q == ST_RUNNING);

endmodule

>>> rtl/core/rrts_ctrl.sv
// Command sequencer: decodes a command, steps the token scan and builds the result.
module rrts_ctrl #(
  parameter int unsigned SlotCount = 8,
  parameter int unsigned IdxW      = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rrts_pkg::in_beat_t    in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rrts_pkg::out_beat_t   out_beat_o,
  output rrts_pkg::cell_cmd_t   cell_cmd_o,
  output logic [IdxW-1:0]       cur_idx_o,
  output logic [IdxW-1:0]       sel_idx_o,
  input  logic                  hit_i,
  input  rrts_pkg::slot_state_e sel_state_i
);
  import rrts_pkg::*;

  localparam int unsigned CmpW = IdxW + 4;
  localparam int unsigned ExtW = IdxW + 3;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SlotCount - 1);

  ctrl_state_e     state_q, state_d;
  cmd_e            cmd_q, cmd_d;
  logic [2:0]      tgt_q, tgt_d;
  logic [IdxW-1:0] cur_q, cur_d;
  logic [IdxW-1:0] prev_q, prev_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] step_q, step_d;
  logic [IdxW-1:0] made_q, made_d;
  status_e         status_q, status_d;
  logic            out_valid_q, out_valid_d;
  out_beat_t       out_q, out_d;

  logic [CmpW-1:0] tgt_w;
  logic            join_bad;
  logic [IdxW-1:0] cur_nxt, pos_nxt;
  logic [ExtW-1:0] made_x, prev_x, cur_x;

  assign tgt_w    = CmpW'(tgt_q);
  assign join_bad = (tgt_w >= CmpW'(SlotCount)) || (tgt_w == CmpW'(cur_q)) ||
                    (sel_state_i == ST_UNUSED);
  assign cur_nxt  = (cur_q == LastIdx) ? '0 : cur_q + IdxW'(1);
  assign pos_nxt  = (pos_q == LastIdx) ? '0 : pos_q + IdxW'(1);
  assign made_x   = ExtW'(made_q);
  assign prev_x   = ExtW'(prev_q);
  assign cur_x    = ExtW'(cur_q);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    tgt_d       = tgt_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    pos_d       = pos_q;
    step_d      = step_q;
    made_d      = made_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    sel_idx_o   = pos_q;
    cell_cmd_o.op   = OP_NONE;
    cell_cmd_o.want = (cmd_q == CMD_CREATE) ? ST_UNUSED : ST_RUNNABLE;

    unique case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d    = cmd_e'(in_beat_i.command);
          tgt_d    = in_beat_i.target_thread;
          prev_d   = cur_q;
          made_d   = '0;
          status_d = STATUS_OK;
          state_d  = CS_EXEC;
        end
      end
      CS_EXEC: begin
        unique case (cmd_q)
          CMD_CREATE: begin
            sel_idx_o     = '0;
            cell_cmd_o.op = OP_LOAD;
            pos_d         = '0;
            step_d        = '0;
            state_d       = CS_SCAN;
          end
          CMD_YIELD: begin
            sel_idx_o     = cur_nxt;
            cell_cmd_o.op = OP_LOAD;
            pos_d         = cur_nxt;
            step_d        = '0;
            state_d       = CS_SCAN;
          end
          CMD_EXIT: begin
            cell_cmd_o.op = OP_EXIT;
            pos_d         = cur_nxt;
            state_d       = CS_LOAD;
          end
          CMD_JOIN: begin
            sel_idx_o = tgt_w[IdxW-1:0];
            if (join_bad) begin
              status_d = STATUS_BADJOIN;
              state_d  = CS_FINISH;
            end else if (sel_state_i == ST_ZOMBIE) begin
              cell_cmd_o.op = OP_REAP;
              state_d       = CS_FINISH;
            end else begin
              cell_cmd_o.op = OP_BLOCK;
              status_d      = STATUS_BLOCKED;
              pos_d         = cur_nxt;
              state_d       = CS_LOAD;
            end
          end
          default: begin
          end
        endcase
      end
      CS_LOAD: begin
        cell_cmd_o.op = OP_LOAD;
        step_d        = '0;
        state_d       = CS_SCAN;
      end
      CS_SCAN: begin
        if (hit_i) begin
          if (cmd_q == CMD_CREATE) begin
            cell_cmd_o.op = OP_CREATE_SET;
            made_d        = pos_q;
          end else begin
            cell_cmd_o.op = OP_SWITCH;
            cur_d         = pos_q;
          end
          state_d = CS_FINISH;
        end else if (step_q == LastIdx) begin
          // The token came all the way around without a match.
          if (cmd_q == CMD_CREATE) begin
            status_d = STATUS_FULL;
          end
          state_d = CS_FINISH;
        end else begin
          cell_cmd_o.op = OP_SHIFT;
          pos_d         = pos_nxt;
          step_d        = step_q + IdxW'(1);
        end
      end
      CS_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status          = status_q;
          out_d.created_thread  = made_x[2:0];
          out_d.switched        = (cur_q != prev_q);
          out_d.previous_thread = prev_x[2:0];
          out_d.running_thread  = cur_x[2:0];
          out_valid_d           = 1'b1;
          state_d               = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    tgt_q    <= tgt_d;
    prev_q   <= prev_d;
    pos_q    <= pos_d;
    step_q   <= step_d;
    made_q   <= made_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign cur_idx_o   = cur_q;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

>>> rtl/core/round_robin_thread_scheduler_core.sv
// Top level of the round-robin thread scheduler: a ring of slot cells and a sequencer.
//
//   Channel  | Direction | Handshake            | Beat
//   ---------+-----------+----------------------+-----------------------------
//   in       | input     | in_valid_i/in_ready_o| in_beat_i  (command, target)
//   out      | output    | out_valid_o/out_ready_i | out_beat_o (status, slots)
//
// One command is in flight at a time. Create and yield step EXEC, SCAN, FINISH;
// exit and a blocking join step EXEC, LOAD, SCAN, FINISH; a bad or reaping join
// steps EXEC, FINISH. The search token moves one cell per cycle around the ring.
// Reset puts slot zero running and all others unused, with no clearing pass.
// A result waits in the output register while the next command is accepted;
// a command that finishes while that register is still full holds until it drains.
module round_robin_thread_scheduler_core #(
  parameter int unsigned SlotCount = rrts_pkg::SLOT_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rrts_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rrts_pkg::out_beat_t out_beat_o
);
  import rrts_pkg::*;

  localparam int unsigned IdxW  = $clog2(SlotCount);
  localparam int unsigned WaitW = $clog2(SlotCount + 1);

  cell_cmd_t       cell_cmd;
  logic [IdxW-1:0] cur_idx, sel_idx;
  logic [SlotCount-1:0] token, token_in, match, run;
  logic [2:0]      rd_state [SlotCount];
  logic [2:0]      sel_state;
  logic            hit;

  for (genvar i = 0; i < SlotCount; i++) begin : g_cell
    assign token_in[i] = token[(i + SlotCount - 1) % SlotCount];

    rrts_cell #(
      .SlotCount(SlotCount),
      .CellIdx  (i),
      .IdxW     (IdxW),
      .WaitW    (WaitW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cell_cmd),
      .cur_idx_i (cur_idx),
      .sel_idx_i (sel_idx),
      .token_i   (token_in[i]),
      .token_o   (token[i]),
      .match_o   (match[i]),
      .rd_state_o(rd_state[i]),
      .run_o     (run[i])
    );
  end

  // Only the selected cell drives a nonzero state, so an OR gathers the read.
  always_comb begin
    sel_state = '0;
    for (int i = 0; i < SlotCount; i++) begin
      sel_state = sel_state | rd_state[i];
    end
  end

  assign hit = |match;

  rrts_ctrl #(
    .SlotCount(SlotCount),
    .IdxW     (IdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o),
    .cell_cmd_o (cell_cmd),
    .cur_idx_o  (cur_idx),
    .sel_idx_o  (sel_idx),
    .hit_i      (hit),
    .sel_state_i(slot_state_e'(sel_state))
  );

  a_one_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(run))
    else $error("more than one slot is running");

  a_token_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(token))
    else $error("search token duplicated in the ring");

  a_switch_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_beat_o.switched) |->
      (out_beat_o.previous_thread == out_beat_o.running_thread))
    else $error("running thread changed without the switched flag");

  a_full_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.status == STATUS_FULL) |->
      (out_beat_o.created_thread == 3'd0 && !out_beat_o.switched))
    else $error("failed create reported a slot or a switch");

endmodule
